// ===== sv/indexed_doubly_linked_list_unit_macros.svh =====
// ----------------------------------------------------------------------------
// indexed doubly linked list unit - assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH

// same-cycle implication
`define IDLL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IDLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// shared types and constants of the indexed doubly linked list unit
// ----------------------------------------------------------------------------
package idll_pkg;

   localparam int ID_W        = 10;
   localparam int CMD_W       = 2;
   localparam int DEF_MAX_ID  = 1023;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   // classified operation as handed to the back end
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_QUERY,
      OP_REMOVE,
      OP_QZERO
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] position;
      logic [ID_W-1:0] new_id;
   } item_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE1,
      ST_WRITE2,
      ST_RESP
   } back_state_type;

endpackage

// ===== sv/indexed_doubly_linked_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_unit
// doubly linked list of entry ids in two link memories, sentinel at entry 0
// ----------------------------------------------------------------------------
// Each request item is one command: insert new_id after position (position 0
// inserts at the head), query the successor of position (position 0 gives the
// head, the tail gives 0), or remove position. Only a query returns an item.
// Commands with an id above MAX_ID change nothing; such a query returns 0.
// Command code 3 is dropped. After reset a clearing pass writes every entry of
// both link memories, one entry a cycle, MAX_ID+1 entries in all (1024 at the
// default); req_tready stays low until it is done and the list then holds
// entry 1 alone. In the back end an insert or a remove is one link read, then
// two writes, since each link memory has one write port; a query is one link
// read, then a wait for the result register to be free. A two-item queue sits
// between front and back, so requests are taken while a result waits to be
// picked up.
module indexed_doubly_linked_list_unit #(
   parameter int MAX_ID = idll_pkg::DEF_MAX_ID
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [idll_pkg::REQ_DATA_W-1:0] req_tdata,  // position[9:0], new_id[19:10]
   input  logic [idll_pkg::CMD_W-1:0]      req_tuser,  // cmd[1:0]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [idll_pkg::RSP_DATA_W-1:0] rsp_tdata   // next_id[9:0]
);
   import idll_pkg::*;

   // unpacked request fields
   logic [ID_W-1:0] req_position;
   logic [ID_W-1:0] req_new_id;
   logic [ID_W-1:0] rsp_next_id;

   // front to back queue head and back to front control
   item_type     head;
   logic         head_valid;
   back_ctl_type back_ctl;

   assign req_position = req_tdata[ID_W-1:0];
   assign req_new_id   = req_tdata[2*ID_W-1:ID_W];

   // front: id checks, dropping of no-op commands, item queue
   idll_front #(.MAX_ID(MAX_ID)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_cmd      (req_tuser),
      .req_position (req_position),
      .req_new_id   (req_new_id),
      .head         (head),
      .head_valid   (head_valid),
      .back_ctl     (back_ctl)
   );

   // back: clearing pass, link memory sequencing, result register
   idll_back #(.MAX_ID(MAX_ID)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .back_ctl    (back_ctl),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_next_id (rsp_next_id)
   );

   // zero fill up to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - ID_W){1'b0}}, rsp_next_id};

endmodule

// ===== sv/idll_ram.sv =====
// ----------------------------------------------------------------------------
// idll_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module idll_ram #(
   parameter  int WIDTH  = 10,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // output holds while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/idll_front.sv =====
// ----------------------------------------------------------------------------
// idll_front
// accepts commands, checks ids, drops no-op commands, queues the rest
// ----------------------------------------------------------------------------
module idll_front #(
   parameter int MAX_ID = idll_pkg::DEF_MAX_ID
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [idll_pkg::CMD_W-1:0]  req_cmd,
   input  logic [idll_pkg::ID_W-1:0]   req_position,
   input  logic [idll_pkg::ID_W-1:0]   req_new_id,
   output idll_pkg::item_type          head,
   output logic                        head_valid,
   input  idll_pkg::back_ctl_type      back_ctl
);
   import idll_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   logic     pos_ok, nid_ok, keep, push, pop;
   item_type item;

   assign pos_ok = (32'(req_position) <= MAX_ID);
   assign nid_ok = (32'(req_new_id) <= MAX_ID);

   always_comb begin
      keep          = 1'b0;
      item.op       = OP_QZERO;
      item.position = req_position;
      item.new_id   = req_new_id;
      case (req_cmd)
         CMD_INSERT: begin
            keep    = pos_ok && nid_ok;
            item.op = OP_INSERT;
         end
         CMD_QUERY: begin
            // an out of range query still answers, with zero
            keep    = 1'b1;
            item.op = pos_ok ? OP_QUERY : OP_QZERO;
         end
         CMD_REMOVE: begin
            keep    = pos_ok;
            item.op = OP_REMOVE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = !back_ctl.clearing && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = back_ctl.pop;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item;
      end
   end

   assign head       = q_mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

`include "indexed_doubly_linked_list_unit_macros.svh"

   `IDLL_ASSERT_IMPL(a_pop_not_empty, pop, count_ff != '0, "pop from empty queue")
   `IDLL_ASSERT_IMPL(a_empty_ptrs, count_ff == '0, rd_ptr_ff == wr_ptr_ff, "queue pointers skewed")

endmodule

// ===== sv/idll_back.sv =====
// ----------------------------------------------------------------------------
// idll_back
// executes queued commands on the two link memories, holds the result
// ----------------------------------------------------------------------------
module idll_back #(
   parameter int MAX_ID = idll_pkg::DEF_MAX_ID
) (
   input  logic                      clock,
   input  logic                      reset,
   input  idll_pkg::item_type        head,
   input  logic                      head_valid,
   output idll_pkg::back_ctl_type    back_ctl,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [idll_pkg::ID_W-1:0] rsp_next_id
);
   import idll_pkg::*;

   localparam int DEPTH  = MAX_ID + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   item_type          item_ff, item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_next_id_ff, rsp_next_id_in;

   logic              next_we, prev_we, next_re, prev_re;
   logic [ADDR_W-1:0] next_waddr, prev_waddr, next_raddr, prev_raddr;
   logic [ID_W-1:0]   next_wdata, prev_wdata, next_rdata, prev_rdata;

   logic              pop, rsp_load, x_zero;
   logic [ID_W-1:0]   x, y, result;

   idll_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .re    (next_re),
      .raddr (next_raddr),
      .rdata (next_rdata)
   );

   idll_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_ram (
      .clock (clock),
      .we    (prev_we),
      .waddr (prev_waddr),
      .wdata (prev_wdata),
      .re    (prev_re),
      .raddr (prev_raddr),
      .rdata (prev_rdata)
   );

   assign x      = item_ff.position;
   assign y      = item_ff.new_id;
   assign x_zero = (x == '0);

   // query answer from the held read data: next of x, zero at the tail
   always_comb begin
      if (item_ff.op == OP_QZERO) begin
         result = '0;
      end else if (x_zero) begin
         result = next_rdata;
      end else if (x == prev_rdata) begin
         result = '0;
      end else begin
         result = next_rdata;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      item_in        = item_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_next_id_in = rsp_next_id_ff;
      pop            = 1'b0;
      rsp_load       = 1'b0;
      next_we        = 1'b0;
      prev_we        = 1'b0;
      next_waddr     = ADDR_W'(x);
      prev_waddr     = ADDR_W'(x);
      next_wdata     = '0;
      prev_wdata     = '0;
      next_re        = 1'b0;
      prev_re        = 1'b0;
      next_raddr     = ADDR_W'(head.position);
      prev_raddr     = ADDR_W'(head.position);
      case (state_ff)
         ST_CLEAR: begin
            next_we    = 1'b1;
            prev_we    = 1'b1;
            next_waddr = clr_ff;
            prev_waddr = clr_ff;
            next_wdata = (clr_ff == '0) ? ID_W'(1) : '0;
            prev_wdata = (clr_ff == '0) ? ID_W'(1) : '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_ID)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               item_in = head;
               next_re = 1'b1;
               prev_re = 1'b1;
               // a query needs the tail to spot the end of the list
               if (head.op == OP_QUERY) begin
                  prev_raddr = '0;
               end
               if (head.op == OP_INSERT || head.op == OP_REMOVE) begin
                  state_in = ST_WRITE1;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WRITE1: begin
            next_we  = 1'b1;
            prev_we  = 1'b1;
            state_in = ST_WRITE2;
            if (item_ff.op == OP_INSERT) begin
               // next[x] = y; prev[y] = x, or prev[old head] = y at the head
               next_waddr = ADDR_W'(x);
               next_wdata = y;
               prev_waddr = x_zero ? ADDR_W'(next_rdata) : ADDR_W'(y);
               prev_wdata = x_zero ? y : x;
            end else begin
               // bridge the neighbors: next[p] = q, prev[q] = p
               next_waddr = ADDR_W'(prev_rdata);
               next_wdata = next_rdata;
               prev_waddr = ADDR_W'(next_rdata);
               prev_wdata = prev_rdata;
            end
         end
         ST_WRITE2: begin
            next_we  = 1'b1;
            prev_we  = 1'b1;
            state_in = ST_IDLE;
            if (item_ff.op == OP_INSERT) begin
               // next[y] = old successor; prev[old successor] = y, or prev[y] = 0
               next_waddr = ADDR_W'(y);
               next_wdata = next_rdata;
               prev_waddr = x_zero ? ADDR_W'(y) : ADDR_W'(next_rdata);
               prev_wdata = x_zero ? '0 : y;
            end else begin
               // clear the removed entry
               next_waddr = ADDR_W'(x);
               next_wdata = '0;
               prev_waddr = ADDR_W'(x);
               prev_wdata = '0;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load       = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_next_id_in = result;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff        <= item_in;
      rsp_next_id_ff <= rsp_next_id_in;
   end

   assign back_ctl.clearing = (state_ff == ST_CLEAR);
   assign back_ctl.pop      = pop;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_next_id       = rsp_next_id_ff;

`include "indexed_doubly_linked_list_unit_macros.svh"

   `IDLL_ASSERT_IMPL(a_pop_in_idle, pop, state_ff == ST_IDLE && head_valid, "pop outside idle")
   `IDLL_ASSERT_NEXT(a_write_pair, state_ff == ST_WRITE1, state_ff == ST_WRITE2, "write pair broken")
   `IDLL_ASSERT_IMPL(a_load_free, rsp_load, !rsp_valid_ff || rsp_tready, "result overwritten")

endmodule
